// ===== rtl/tga_pkg.sv =====
package tga_pkg;

  // Header layout and format codes
  localparam int unsigned HEADER_BYTES = 18;
  localparam logic [7:0] TYPE_TRUE_COLOUR = 8'd2;
  localparam logic [7:0] TYPE_GREY = 8'd3;
  localparam logic [7:0] DEPTH_32 = 8'd32;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_8 = 8'd8;
  localparam int unsigned DESC_TOP_LEFT_BIT = 5;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } tga_kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HEADER_SHORT = 3'd1,
    ST_BAD_TYPE     = 3'd2,
    ST_ZERO_SIZE    = 3'd3,
    ST_TRUNCATED    = 3'd4,
    ST_BAD_DEPTH    = 3'd5
  } tga_status_t;

  typedef struct packed {
    tga_kind_t   item_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] dest_column;
    logic [15:0] dest_row;
    tga_status_t status_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        final_item;
  } tga_item_t;

endpackage

// ===== rtl/tga_byte_if.sv =====
interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

// ===== rtl/tga_item_if.sv =====
interface tga_item_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] dest_column;
  logic [15:0] dest_row;
  logic [2:0]  status_code;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        final_item;

  modport source (
    output valid, item_kind, red, green, blue, alpha, dest_column, dest_row,
           status_code, image_width, image_height, final_item,
    input  ready
  );
  modport sink (
    input  valid, item_kind, red, green, blue, alpha, dest_column, dest_row,
           status_code, image_width, image_height, final_item,
    output ready
  );
endinterface

// ===== rtl/tga_stream_pixel_decoder.sv =====
// Streaming decoder for uncompressed TGA files (true colour or greyscale at
// 32, 24 or 8 bits per pixel). One file byte is taken per cycle while the
// result queue has room; a pixel item is queued as its last byte is accepted,
// tagged with its destination column and row (row mirrored unless descriptor
// bit 5 is set), so no frame buffer is needed. The byte flagged end_of_file
// also produces a status item, after any pixel it completes; discard all
// pixels of a file whose status is not ok. Results pass through a four-entry
// queue, and the byte input stalls while fewer than two queue slots are free:
// with a sink that takes one item per cycle the block sustains one byte per
// cycle, and a last byte that both finishes a pixel and ends the file pushes
// two items at once. After the status item the decoder is ready for a new file.
module tga_stream_pixel_decoder import tga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tga_byte_if.sink   data,
  tga_item_if.source result
);

  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_MAP_TYPE   = 5'd1;
  localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;
  localparam logic [4:0] HDR_DONE       = 5'(HEADER_BYTES);

  logic [4:0]  header_position, header_position_next;
  logic [7:0]  id_skip_left, id_skip_left_next;
  logic [7:0]  map_type_seen, map_type_seen_next;
  logic [7:0]  kind_of_image, kind_of_image_next;
  logic [15:0] width_seen, width_seen_next;
  logic [15:0] height_seen, height_seen_next;
  logic [7:0]  depth_seen, depth_seen_next;
  logic [7:0]  descriptor_seen, descriptor_seen_next;
  logic [23:0] pixel_assembly, pixel_assembly_next;
  logic [4:0]  byte_in_pixel, byte_in_pixel_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;

  logic        accept;
  logic        room;
  logic [4:0]  bpp_bytes;
  logic        pixel_phase;
  logic        last_of_pixel;
  logic [16:0] column_inc;
  logic        pixel_emit;
  logic        status_emit;
  logic [1:0]  push_count;
  tga_item_t   pixel_item;
  tga_item_t   status_item;
  tga_item_t   first;
  tga_item_t   second;
  tga_status_t status;

  function automatic logic type_ok(input logic [7:0] map_type, input logic [7:0] kind);
    return (map_type == 8'd0) && (kind == TYPE_TRUE_COLOUR || kind == TYPE_GREY);
  endfunction

  function automatic logic depth_ok(input logic [7:0] depth);
    return depth == DEPTH_32 || depth == DEPTH_24 || depth == DEPTH_8;
  endfunction

  assign accept = data.valid && data.ready;
  assign data.ready = room;
  assign bpp_bytes = depth_seen[7:3];
  assign pixel_phase = (header_position >= HDR_DONE) && (id_skip_left == 8'd0) &&
                       type_ok(map_type_seen, kind_of_image) &&
                       (width_seen != 16'd0) && (height_seen != 16'd0) &&
                       (bpp_bytes != 5'd0) && (row_count < height_seen);
  assign last_of_pixel = ({1'b0, byte_in_pixel} + 6'd1) >= {1'b0, bpp_bytes};
  assign column_inc = {1'b0, column_count} + 17'd1;

  // Build the pixel from the gathered bytes and the current one
  always_comb begin
    pixel_item = '0;
    pixel_item.item_kind = KIND_PIXEL;
    pixel_item.status_code = ST_OK;
    pixel_item.dest_column = column_count;
    pixel_item.dest_row = descriptor_seen[DESC_TOP_LEFT_BIT] ? row_count
                          : (height_seen - 16'd1 - row_count);
    pixel_item.image_width = width_seen;
    pixel_item.image_height = height_seen;
    pixel_item.final_item = 1'b0;
    if (depth_seen == DEPTH_8) begin
      pixel_item.red = data.data_byte;
      pixel_item.green = data.data_byte;
      pixel_item.blue = data.data_byte;
      pixel_item.alpha = ALPHA_OPAQUE;
    end else if (depth_seen == DEPTH_24) begin
      pixel_item.blue = pixel_assembly[7:0];
      pixel_item.green = pixel_assembly[15:8];
      pixel_item.red = data.data_byte;
      pixel_item.alpha = ALPHA_OPAQUE;
    end else begin
      pixel_item.blue = pixel_assembly[7:0];
      pixel_item.green = pixel_assembly[15:8];
      pixel_item.red = pixel_assembly[23:16];
      pixel_item.alpha = data.data_byte;
    end
  end

  // Advance the parser on each accepted byte
  always_comb begin
    header_position_next = header_position;
    id_skip_left_next = id_skip_left;
    map_type_seen_next = map_type_seen;
    kind_of_image_next = kind_of_image;
    width_seen_next = width_seen;
    height_seen_next = height_seen;
    depth_seen_next = depth_seen;
    descriptor_seen_next = descriptor_seen;
    pixel_assembly_next = pixel_assembly;
    byte_in_pixel_next = byte_in_pixel;
    column_count_next = column_count;
    row_count_next = row_count;
    pixel_emit = 1'b0;
    if (accept) begin
      if (header_position < HDR_DONE) begin
        unique case (header_position)
          HDR_ID_LEN:     id_skip_left_next = data.data_byte;
          HDR_MAP_TYPE:   map_type_seen_next = data.data_byte;
          HDR_IMAGE_TYPE: kind_of_image_next = data.data_byte;
          HDR_WIDTH_LO:   width_seen_next[7:0] = data.data_byte;
          HDR_WIDTH_HI:   width_seen_next[15:8] = data.data_byte;
          HDR_HEIGHT_LO:  height_seen_next[7:0] = data.data_byte;
          HDR_HEIGHT_HI:  height_seen_next[15:8] = data.data_byte;
          HDR_DEPTH:      depth_seen_next = data.data_byte;
          HDR_DESCRIPTOR: descriptor_seen_next = data.data_byte;
          default: ;
        endcase
        header_position_next = header_position + 5'd1;
      end else if (id_skip_left != 8'd0) begin
        id_skip_left_next = id_skip_left - 8'd1;
      end else if (pixel_phase) begin
        if (last_of_pixel) begin
          pixel_emit = depth_ok(depth_seen);
          pixel_assembly_next = '0;
          byte_in_pixel_next = '0;
          if (column_inc >= {1'b0, width_seen}) begin
            column_count_next = '0;
            row_count_next = row_count + 16'd1;
          end else begin
            column_count_next = column_inc[15:0];
          end
        end else begin
          case (byte_in_pixel)
            5'd0: pixel_assembly_next[7:0] = data.data_byte;
            5'd1: pixel_assembly_next[15:8] = data.data_byte;
            5'd2: pixel_assembly_next[23:16] = data.data_byte;
            default: ;
          endcase
          byte_in_pixel_next = byte_in_pixel + 5'd1;
        end
      end
    end
  end

  // Judge the file from the state it leaves
  always_comb begin
    if (header_position_next < HDR_DONE) begin
      status = ST_HEADER_SHORT;
    end else if (!type_ok(map_type_seen_next, kind_of_image_next)) begin
      status = ST_BAD_TYPE;
    end else if (width_seen_next == 16'd0 || height_seen_next == 16'd0) begin
      status = ST_ZERO_SIZE;
    end else if (id_skip_left_next != 8'd0 ||
                 (depth_seen_next[7:3] != 5'd0 && row_count_next < height_seen_next)) begin
      status = ST_TRUNCATED;
    end else if (!depth_ok(depth_seen_next)) begin
      status = ST_BAD_DEPTH;
    end else begin
      status = ST_OK;
    end
    status_item = '0;
    status_item.item_kind = KIND_STATUS;
    status_item.status_code = status;
    status_item.final_item = 1'b1;
    if (status != ST_HEADER_SHORT) begin
      status_item.image_width = width_seen_next;
      status_item.image_height = height_seen_next;
    end
  end

  // Order the transactions: pixel first, then status
  assign status_emit = accept && data.end_of_file;
  assign push_count = {1'b0, pixel_emit} + {1'b0, status_emit};
  assign first = pixel_emit ? pixel_item : status_item;
  assign second = status_item;

  // Hold parser state; drop it all after the last byte
  always_ff @(posedge clk) begin
    if (rst || status_emit) begin
      header_position <= '0;
      id_skip_left <= '0;
      map_type_seen <= '0;
      kind_of_image <= '0;
      width_seen <= '0;
      height_seen <= '0;
      depth_seen <= '0;
      descriptor_seen <= '0;
      pixel_assembly <= '0;
      byte_in_pixel <= '0;
      column_count <= '0;
      row_count <= '0;
    end else begin
      header_position <= header_position_next;
      id_skip_left <= id_skip_left_next;
      map_type_seen <= map_type_seen_next;
      kind_of_image <= kind_of_image_next;
      width_seen <= width_seen_next;
      height_seen <= height_seen_next;
      depth_seen <= depth_seen_next;
      descriptor_seen <= descriptor_seen_next;
      pixel_assembly <= pixel_assembly_next;
      byte_in_pixel <= byte_in_pixel_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

  tga_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .first      (first),
    .second     (second),
    .room       (room),
    .result     (result)
  );

  // A final byte always restarts the header
  assert property (@(posedge clk) disable iff (rst)
    accept && data.end_of_file |=> header_position == 5'd0)
    else $error("parser not cleared after final byte");

  // The column stays inside the image once the header is complete
  assert property (@(posedge clk) disable iff (rst)
    (header_position == HDR_DONE) && (width_seen != 16'd0) |-> column_count < width_seen)
    else $error("column count ran past image width");

  // The input only stalls when results are waiting
  assert property (@(posedge clk) disable iff (rst)
    !data.ready |-> result.valid)
    else $error("input stalled with empty result queue");

  // A pixel never shows up in the same transaction as a pushed-out header
  assert property (@(posedge clk) disable iff (rst)
    pixel_emit |-> header_position == HDR_DONE && id_skip_left == 8'd0)
    else $error("pixel produced outside pixel data");

endmodule

// ===== rtl/tga_result_queue.sv =====
module tga_result_queue import tga_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  tga_item_t        first,
  input  tga_item_t        second,
  output logic             room,
  tga_item_if.source       result
);

  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  tga_item_t  slots [4];
  tga_item_t  head;

  assign pop = result.valid && result.ready;
  // Leave space for the worst case of two items from one byte
  assign room = (count <= 3'd2);

  // Hold pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count <= count + {1'b0, push_count} - {2'b00, pop};
    end
  end

  // Write up to two transactions in order
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= first;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= second;
    end
  end

  // Present the oldest entry
  assign head = slots[rd_ptr];
  assign result.valid = (count != 3'd0);
  assign result.item_kind = head.item_kind;
  assign result.red = head.red;
  assign result.green = head.green;
  assign result.blue = head.blue;
  assign result.alpha = head.alpha;
  assign result.dest_column = head.dest_column;
  assign result.dest_row = head.dest_row;
  assign result.status_code = head.status_code;
  assign result.image_width = head.image_width;
  assign result.image_height = head.image_height;
  assign result.final_item = head.final_item;

endmodule

// ===== bench/tga_item_checker.sv =====
module tga_item_checker import tga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tga_byte_if         data,
  tga_item_if         result,
  output int unsigned fail_count,
  output int unsigned awaited_count,
  output int unsigned pixels_checked,
  output int unsigned files_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder state as the file is parsed
  logic [4:0]  hdr_pos;
  logic [7:0]  id_left;
  logic [7:0]  map_type_q;
  logic [7:0]  img_type_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [7:0]  depth_q;
  logic [7:0]  descr_q;
  logic [23:0] assembly;
  logic [4:0]  pix_idx;
  logic [15:0] column_q;
  logic [16:0] row_q;

  // Decoded items still waiting to leave the block, oldest first
  tga_item_t awaited_items[$];

  task automatic clear_file_state();
    hdr_pos    = '0;
    id_left    = '0;
    map_type_q = '0;
    img_type_q = '0;
    width_q    = '0;
    height_q   = '0;
    depth_q    = '0;
    descr_q    = '0;
    assembly   = '0;
    pix_idx    = '0;
    column_q   = '0;
    row_q      = '0;
  endtask

  function automatic bit format_ok();
    return map_type_q == 8'd0 && (img_type_q == TYPE_TRUE_COLOUR || img_type_q == TYPE_GREY);
  endfunction

  function automatic bit depth_supported();
    return depth_q == DEPTH_32 || depth_q == DEPTH_24 || depth_q == DEPTH_8;
  endfunction

  // Work out the items caused by one accepted file byte
  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [7:0]  bpp;
    logic [15:0] drow;
    tga_item_t   px;
    tga_item_t   st;
    tga_status_t code;
    bpp = depth_q >> 3;
    if (hdr_pos < HEADER_BYTES) begin
      case (hdr_pos)
        5'd0:  id_left = b;
        5'd1:  map_type_q = b;
        5'd2:  img_type_q = b;
        5'd12: width_q[7:0] = b;
        5'd13: width_q[15:8] = b;
        5'd14: height_q[7:0] = b;
        5'd15: height_q[15:8] = b;
        5'd16: depth_q = b;
        5'd17: descr_q = b;
        default: ;
      endcase
      hdr_pos++;
    end else if (id_left != 8'd0) begin
      id_left--;
    end else if (format_ok() && width_q != 16'd0 && height_q != 16'd0 && bpp != 8'd0 &&
                 row_q < {1'b0, height_q}) begin
      if (pix_idx < 5'd3)
        assembly[pix_idx*8 +: 8] = assembly[pix_idx*8 +: 8] | b;
      if (int'(pix_idx) + 1 >= int'(bpp)) begin
        if (depth_supported()) begin
          drow = descr_q[DESC_TOP_LEFT_BIT] ? row_q[15:0] : height_q - 16'd1 - row_q[15:0];
          px = '0;
          px.item_kind = KIND_PIXEL;
          if (depth_q == DEPTH_8) begin
            px.red   = b;
            px.green = b;
            px.blue  = b;
            px.alpha = ALPHA_OPAQUE;
          end else begin
            px.blue  = assembly[7:0];
            px.green = assembly[15:8];
            if (depth_q == DEPTH_24) begin
              px.red   = b;
              px.alpha = ALPHA_OPAQUE;
            end else begin
              px.red   = assembly[23:16];
              px.alpha = b;
            end
          end
          px.dest_column  = column_q;
          px.dest_row     = drow;
          px.status_code  = ST_OK;
          px.image_width  = width_q;
          px.image_height = height_q;
          px.final_item   = 1'b0;
          awaited_items = {awaited_items, px};
        end
        assembly = '0;
        pix_idx  = '0;
        // Advance the raster position
        if (int'(column_q) + 1 >= int'(width_q)) begin
          column_q = '0;
          row_q++;
        end else begin
          column_q++;
        end
      end else begin
        pix_idx++;
      end
    end

    // Close the file with its status
    if (eof) begin
      bpp = depth_q >> 3;
      if (hdr_pos < HEADER_BYTES)
        code = ST_HEADER_SHORT;
      else if (!format_ok())
        code = ST_BAD_TYPE;
      else if (width_q == 16'd0 || height_q == 16'd0)
        code = ST_ZERO_SIZE;
      else if (id_left != 8'd0 || (bpp != 8'd0 && row_q < {1'b0, height_q}))
        code = ST_TRUNCATED;
      else if (!depth_supported())
        code = ST_BAD_DEPTH;
      else
        code = ST_OK;
      st = '0;
      st.item_kind   = KIND_STATUS;
      st.status_code = code;
      if (code != ST_HEADER_SHORT) begin
        st.image_width  = width_q;
        st.image_height = height_q;
      end
      st.final_item = 1'b1;
      awaited_items = {awaited_items, st};
      clear_file_state();
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare one transaction on the result channel with the oldest prediction
  task automatic compare_item();
    tga_item_t want;
    if (awaited_items.size() == 0) begin
      $error("result transaction with no item expected (kind %0d)", result.item_kind);
      fail_count++;
    end else begin
      want = awaited_items.pop_front();
      check_field("item_kind", want.item_kind, result.item_kind);
      check_field("red", want.red, result.red);
      check_field("green", want.green, result.green);
      check_field("blue", want.blue, result.blue);
      check_field("alpha", want.alpha, result.alpha);
      check_field("dest_column", want.dest_column, result.dest_column);
      check_field("dest_row", want.dest_row, result.dest_row);
      check_field("status_code", want.status_code, result.status_code);
      check_field("image_width", want.image_width, result.image_width);
      check_field("image_height", want.image_height, result.image_height);
      check_field("final_item", want.final_item, result.final_item);
      if (want.item_kind == KIND_STATUS)
        files_checked++;
      else
        pixels_checked++;
    end
  endtask

  // Watch both channels; a result never stems from a byte taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_file_state();
      awaited_items.delete();
      fail_count     = 0;
      awaited_count  = 0;
      pixels_checked = 0;
      files_checked  = 0;
    end else begin
      if (result.valid && result.ready)
        compare_item();
      if (data.valid && data.ready)
        decode_byte(data.data_byte, data.end_of_file);
      awaited_count = awaited_items.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench import tga_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BYTE_TARGET = 1150;

  logic clk;
  logic rst;
  bit steady;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned fail_count;
  int unsigned awaited_count;
  int unsigned pixels_checked;
  int unsigned files_checked;
  logic [7:0] file_bytes[$];

  tga_byte_if data_ch();
  tga_item_if result_ch();

  tga_stream_pixel_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .data   (data_ch),
    .result (result_ch)
  );

  tga_item_checker item_check (
    .clk            (clk),
    .rst            (rst),
    .data           (data_ch),
    .result         (result_ch),
    .fail_count     (fail_count),
    .awaited_count  (awaited_count),
    .pixels_checked (pixels_checked),
    .files_checked  (files_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result sink: stall at random except in the steady stretch
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  // Offer one byte, idling at random first, and hold it until taken
  task automatic send_byte(input logic [7:0] value, input logic last);
    while (!steady && $urandom_range(99) < 21) begin
      data_ch.valid <= 1'b0;
      @(posedge clk);
    end
    data_ch.valid       <= 1'b1;
    data_ch.data_byte   <= value;
    data_ch.end_of_file <= last;
    @(posedge clk);
    while (!data_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  // Add one byte to the end of the file being built
  task automatic append_byte(input logic [7:0] value);
    file_bytes = {file_bytes, value};
  endtask

  task automatic push_header(input logic [7:0] id_len, input logic [7:0] map_type,
                             input logic [7:0] img_type, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth,
                             input logic [7:0] desc);
    append_byte(id_len);
    append_byte(map_type);
    append_byte(img_type);
    // Colour map spec and origin are ignored: fill with noise
    repeat (9) append_byte(8'($urandom_range(255)));
    append_byte(w[7:0]);
    append_byte(w[15:8]);
    append_byte(h[7:0]);
    append_byte(h[15:8]);
    append_byte(depth);
    append_byte(desc);
  endtask

  // Build one random file: mostly well formed, the rest broken in one way
  task automatic make_file();
    int unsigned pick;
    int unsigned id_len;
    int unsigned w;
    int unsigned h;
    int unsigned keep;
    longint unsigned body;
    logic [7:0] map_type;
    logic [7:0] img_type;
    logic [7:0] depth;
    logic [7:0] desc;
    bit cut;
    bit noise;
    bit good;
    pick   = $urandom_range(99);
    cut    = 1'b0;
    noise  = 1'b0;
    good   = 1'b0;
    id_len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    map_type = 8'd0;
    img_type = $urandom_range(1) ? TYPE_TRUE_COLOUR : TYPE_GREY;
    case ($urandom_range(2))
      0: depth = DEPTH_8;
      1: depth = DEPTH_24;
      default: depth = DEPTH_32;
    endcase
    w    = $urandom_range(1, 3);
    h    = $urandom_range(1, 3);
    desc = 8'($urandom_range(255));
    if (pick < 60) begin
      good = 1'b1;
      if ($urandom_range(9) == 0) begin
        w     = $urandom_range(4, 24);
        h     = $urandom_range(1, 4);
        depth = DEPTH_8;
      end
    end else if (pick < 70) begin
      cut = 1'b1;
    end else if (pick < 75) begin
      // Bad type: colour map present or unknown image type
      if ($urandom_range(1)) begin
        map_type = 8'($urandom_range(1, 255));
      end else begin
        img_type = 8'($urandom_range(255));
        if (img_type == TYPE_TRUE_COLOUR || img_type == TYPE_GREY)
          img_type = img_type ^ 8'h80;
      end
    end else if (pick < 80) begin
      case ($urandom_range(2))
        0: w = 0;
        1: h = 0;
        default: begin
          w = 0;
          h = 0;
        end
      endcase
    end else if (pick < 88) begin
      // Unsupported depth, below a byte half of the time
      depth = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
      if (depth == DEPTH_8 || depth == DEPTH_24 || depth == DEPTH_32)
        depth = depth ^ 8'h01;
      w = $urandom_range(1, 2);
      h = $urandom_range(1, 2);
    end else if (pick < 93) begin
      w   = $urandom_range(1) ? 16'hFFFF : $urandom_range(65535);
      h   = $urandom_range(1) ? 16'hFFFF : $urandom_range(65535);
      cut = 1'b1;
    end else if (pick < 97) begin
      id_len = $urandom_range(4, 255);
      cut    = $urandom_range(1);
    end else begin
      noise = 1'b1;
    end

    file_bytes.delete();
    if (noise) begin
      repeat ($urandom_range(1, 30)) append_byte(8'($urandom_range(255)));
    end else begin
      push_header(id_len[7:0], map_type, img_type, w[15:0], h[15:0], depth, desc);
      body = longint'(id_len) + longint'(w) * longint'(h) * longint'(depth >> 3);
      if (cut && body > 40)
        body = 40;
      repeat (body) append_byte(8'($urandom_range(255)));
      // Trailing bytes past the last pixel
      if (good && $urandom_range(3) == 0)
        repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(255)));
      if (cut) begin
        keep = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
    end
  endtask

  // Stimulus
  initial begin
    data_ch.valid       <= 1'b0;
    data_ch.data_byte   <= 8'd0;
    data_ch.end_of_file <= 1'b0;
    rst                 <= 1'b1;
    steady     = 1'b0;
    bytes_sent = 0;
    files_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A one-byte file ends inside the header
    file_bytes = '{8'hFF};
    send_file();
    // Smallest image: one grey pixel, bottom-up, pixel and status on one byte
    file_bytes.delete();
    push_header(8'd0, 8'd0, TYPE_GREY, 16'd1, 16'd1, DEPTH_8, 8'h00);
    append_byte(8'h00);
    send_file();

    // Random files, with a stretch of back-to-back traffic on both sides
    while (bytes_sent < BYTE_TARGET) begin
      steady = (files_sent >= 12 && files_sent < 20);
      make_file();
      send_file();
    end
    steady = 1'b0;
    data_ch.valid <= 1'b0;

    // Drain the remaining results
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d bytes in %0d files; checked %0d pixels and %0d status items.",
             bytes_sent, files_sent, pixels_checked, files_checked);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
